// ----- rtl/stable_min_priority_queue_assert.svh -----
// Assertion macros shared by the checker of the stable priority queue.
`ifndef STABLE_MIN_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_MIN_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define SMPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define SMPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/smpq_pkg.sv -----
// Package of the stable priority queue: sizes, codes and shared types.
package smpq_pkg;

  localparam int CAPACITY      = 16;
  localparam int VALUE_BITS    = 32;
  localparam int PRIORITY_BITS = 16;
  localparam int OCC_BITS      = $clog2(CAPACITY + 1);

  typedef enum logic {
    KIND_ENQ = 1'b0,
    KIND_DEQ = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    FAULT_OK    = 2'd0,
    FAULT_FULL  = 2'd1,
    FAULT_EMPTY = 2'd2
  } fault_t;

  // Operation broadcast to every cell of the row.
  typedef struct packed {
    logic                     enq;
    logic                     deq;
    logic [VALUE_BITS-1:0]    value;
    logic [PRIORITY_BITS-1:0] prio;
  } op_t;

  // What a cell shows its neighbours.
  typedef struct packed {
    logic                     valid;
    logic                     ge;
    logic [VALUE_BITS-1:0]    value;
    logic [PRIORITY_BITS-1:0] prio;
  } nbr_t;

  // Contents of one cell.
  typedef struct packed {
    logic                     valid;
    logic [VALUE_BITS-1:0]    value;
    logic [PRIORITY_BITS-1:0] prio;
  } slot_t;

endpackage

// ----- rtl/smpq_if.sv -----
// Channel interfaces of the stable priority queue: input and result.
interface smpq_in_if;
  logic                                  valid;
  logic                                  ready;
  smpq_pkg::kind_t                       kind;
  logic [smpq_pkg::VALUE_BITS-1:0]       item_value;
  logic [smpq_pkg::PRIORITY_BITS-1:0]    item_priority;

  modport source (output valid, kind, item_value, item_priority, input ready);
  modport sink   (input valid, kind, item_value, item_priority, output ready);
endinterface

interface smpq_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [smpq_pkg::VALUE_BITS-1:0]       head_value;
  logic [smpq_pkg::PRIORITY_BITS-1:0]    head_priority;
  logic [smpq_pkg::OCC_BITS-1:0]         occupancy;
  logic                                  is_empty;
  smpq_pkg::fault_t                      fault;

  modport source (output valid, head_value, head_priority, occupancy, is_empty, fault,
                  input ready);
  modport sink   (input valid, head_value, head_priority, occupancy, is_empty, fault,
                  output ready);
endinterface

// ----- rtl/smpq_cell.sv -----
// One cell of the sorted row: holds one entry and shifts with its neighbours.
module smpq_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  smpq_pkg::op_t   op_i,
  input  smpq_pkg::nbr_t  left_i,
  input  smpq_pkg::nbr_t  right_i,
  output smpq_pkg::nbr_t  self_o,
  output smpq_pkg::slot_t nxt_o
);

  logic                               valid_r;
  logic [smpq_pkg::VALUE_BITS-1:0]    value_r;
  logic [smpq_pkg::PRIORITY_BITS-1:0] priority_r;
  logic                               ge;
  smpq_pkg::slot_t                    slot_nxt;

  // An entry stays put when it sorts at or before the new one.
  assign ge = valid_r && (priority_r <= op_i.prio);

  always_comb begin
    slot_nxt = '{valid: valid_r, value: value_r, prio: priority_r};
    if (op_i.enq) begin
      if (!ge) begin
        if (left_i.ge) begin
          slot_nxt = '{valid: 1'b1, value: op_i.value, prio: op_i.prio};
        end else begin
          slot_nxt = '{valid: left_i.valid, value: left_i.value, prio: left_i.prio};
        end
      end
    end else if (op_i.deq) begin
      slot_nxt = '{valid: right_i.valid, value: right_i.value, prio: right_i.prio};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= slot_nxt.valid;
    end
    value_r    <= slot_nxt.value;
    priority_r <= slot_nxt.prio;
  end

  assign self_o = '{valid: valid_r, ge: ge, value: value_r, prio: priority_r};
  assign nxt_o  = slot_nxt;

endmodule

// ----- rtl/stable_min_priority_queue.sv -----
// Top level of the stable priority queue: a row of sorting cells and the result register.
//
//   channel   direction  handshake     payload
//   in_ch     in         valid/ready   kind, item_value, item_priority
//   out_ch    out        valid/ready   head_value, head_priority, occupancy, is_empty, fault
//
// One item is taken per cycle while the output side does not stall; every cell compares
// and shifts in the same cycle, so the result appears in the output register in the
// cycle after the item is taken. The input is ready whenever the output register is
// empty or being emptied. Reset (synchronous, active low) clears the cell valid bits,
// the count and the output valid; no clearing pass is needed.
module stable_min_priority_queue (
  input  logic       clk,
  input  logic       rst_n,
  smpq_in_if.sink    in_ch,
  smpq_out_if.source out_ch
);

  localparam logic [smpq_pkg::OCC_BITS-1:0] FULL_COUNT =
    smpq_pkg::OCC_BITS'(smpq_pkg::CAPACITY);

  smpq_pkg::nbr_t                     self_w [smpq_pkg::CAPACITY];
  smpq_pkg::slot_t                    nxt_w  [smpq_pkg::CAPACITY];
  smpq_pkg::op_t                      op;
  logic                               in_fire;
  logic                               full;
  logic                               empty;
  logic [smpq_pkg::OCC_BITS-1:0]      count_r;
  logic [smpq_pkg::OCC_BITS-1:0]      count_nxt;
  smpq_pkg::fault_t                   fault_nxt;
  logic                               out_valid_r;
  logic [smpq_pkg::VALUE_BITS-1:0]    head_value_r;
  logic [smpq_pkg::PRIORITY_BITS-1:0] head_priority_r;
  logic [smpq_pkg::OCC_BITS-1:0]      occupancy_r;
  logic                               is_empty_r;
  smpq_pkg::fault_t                   fault_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign full        = (count_r == FULL_COUNT);
  assign empty       = (count_r == '0);

  always_comb begin
    op.enq   = in_fire && (in_ch.kind == smpq_pkg::KIND_ENQ) && !full;
    op.deq   = in_fire && (in_ch.kind == smpq_pkg::KIND_DEQ) && !empty;
    op.value = in_ch.item_value;
    op.prio  = in_ch.item_priority;
  end

  always_comb begin
    count_nxt = count_r;
    fault_nxt = smpq_pkg::FAULT_OK;
    if (in_ch.kind == smpq_pkg::KIND_ENQ) begin
      if (full) begin
        fault_nxt = smpq_pkg::FAULT_FULL;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end else begin
      if (empty) begin
        fault_nxt = smpq_pkg::FAULT_EMPTY;
      end else begin
        count_nxt = count_r - 1'b1;
      end
    end
  end

  for (genvar i = 0; i < smpq_pkg::CAPACITY; i++) begin : g_cell
    smpq_pkg::nbr_t left_w;
    smpq_pkg::nbr_t right_w;

    // The head cell sees a full, always-sorted-before neighbour on its left.
    if (i == 0) begin : g_first
      assign left_w = '{valid: 1'b1, ge: 1'b1, value: '0, prio: '0};
    end else begin : g_mid
      assign left_w = self_w[i-1];
    end

    if (i == smpq_pkg::CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner
      assign right_w = self_w[i+1];
    end

    smpq_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .op_i   (op),
      .left_i (left_w),
      .right_i(right_w),
      .self_o (self_w[i]),
      .nxt_o  (nxt_w[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_fire) begin
      head_value_r    <= nxt_w[0].valid ? nxt_w[0].value : '0;
      head_priority_r <= nxt_w[0].valid ? nxt_w[0].prio : '0;
      occupancy_r     <= count_nxt;
      is_empty_r      <= (count_nxt == '0);
      fault_r         <= fault_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.head_value    = head_value_r;
  assign out_ch.head_priority = head_priority_r;
  assign out_ch.occupancy     = occupancy_r;
  assign out_ch.is_empty      = is_empty_r;
  assign out_ch.fault         = fault_r;

endmodule

// ----- rtl/smpq_checker.sv -----
// Port-level assertions of the stable priority queue and their bind.
`include "stable_min_priority_queue_assert.svh"

module smpq_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [smpq_pkg::VALUE_BITS-1:0]    head_value,
  input logic [smpq_pkg::PRIORITY_BITS-1:0] head_priority,
  input logic [smpq_pkg::OCC_BITS-1:0]      occupancy,
  input logic                               is_empty,
  input smpq_pkg::fault_t                   fault
);

  `SMPQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(head_value) && $stable(occupancy) && $stable(fault), "result item changed while stalled")
  `SMPQ_ASSERT_NEXT(a_item_result, in_valid && in_ready, out_valid, "accepted item gave no result")
  `SMPQ_ASSERT_NOW(a_empty_head, out_valid && is_empty, head_value == '0 && head_priority == '0 && occupancy == '0, "empty queue shows a head")
  `SMPQ_ASSERT_NOW(a_full_fault, out_valid && fault == smpq_pkg::FAULT_FULL, occupancy == smpq_pkg::OCC_BITS'(smpq_pkg::CAPACITY) && !is_empty, "full fault without a full queue")

endmodule

bind stable_min_priority_queue smpq_checker u_smpq_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .head_value   (out_ch.head_value),
  .head_priority(out_ch.head_priority),
  .occupancy    (out_ch.occupancy),
  .is_empty     (out_ch.is_empty),
  .fault        (out_ch.fault)
);

// ----- verif/tb_stable_min_priority_queue.sv -----
// Self-checking testbench of the stable priority queue: directed table, then random phases.
module tb_stable_min_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [smpq_pkg::VALUE_BITS-1:0]    head_value;
    logic [smpq_pkg::PRIORITY_BITS-1:0] head_priority;
    logic [smpq_pkg::OCC_BITS-1:0]      occupancy;
    logic                               is_empty;
    smpq_pkg::fault_t                   fault;
  } head_result_t;

  typedef struct {
    smpq_pkg::kind_t                    kind;
    logic [smpq_pkg::VALUE_BITS-1:0]    value;
    logic [smpq_pkg::PRIORITY_BITS-1:0] prio;
    bit                                 typed;
    head_result_t                       want;
  } stim_row_t;

  localparam int RANDOM_PER_PHASE = 263;
  localparam int HOLD_CYCLES      = 60;
  localparam int REPORT_LIMIT     = 10;

  logic clk = 1'b0;
  logic rst_n;

  smpq_in_if  in_bus();
  smpq_out_if out_bus();

  stable_min_priority_queue u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  // Shadow copy of the sorted storage, slot 0 is the head.
  logic [smpq_pkg::VALUE_BITS-1:0]    shadow_values [smpq_pkg::CAPACITY];
  logic [smpq_pkg::PRIORITY_BITS-1:0] shadow_prios  [smpq_pkg::CAPACITY];
  int                                 shadow_count;

  head_result_t pending_heads[$];
  stim_row_t    offered_items[$];
  stim_row_t    directed_rows[$];

  int fail_count;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int hold_count;

  always #6ns clk = ~clk;

  function automatic head_result_t predict_queue_op(stim_row_t row);
    head_result_t r;
    int           pos;
    int           i;
    r.fault = smpq_pkg::FAULT_OK;
    if (row.kind == smpq_pkg::KIND_ENQ) begin
      if (shadow_count >= smpq_pkg::CAPACITY) begin
        r.fault = smpq_pkg::FAULT_FULL;
      end else begin
        // A new entry goes behind every stored entry of equal or smaller priority.
        pos = 0;
        while (pos < shadow_count && shadow_prios[pos] <= row.prio) pos++;
        for (i = shadow_count; i > pos; i--) begin
          shadow_values[i] = shadow_values[i-1];
          shadow_prios[i]  = shadow_prios[i-1];
        end
        shadow_values[pos] = row.value;
        shadow_prios[pos]  = row.prio;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      r.fault = smpq_pkg::FAULT_EMPTY;
    end else begin
      for (i = 1; i < shadow_count; i++) begin
        shadow_values[i-1] = shadow_values[i];
        shadow_prios[i-1]  = shadow_prios[i];
      end
      shadow_count--;
    end
    if (shadow_count == 0) begin
      r.head_value    = '0;
      r.head_priority = '0;
      r.is_empty      = 1'b1;
    end else begin
      r.head_value    = shadow_values[0];
      r.head_priority = shadow_prios[0];
      r.is_empty      = 1'b0;
    end
    r.occupancy = smpq_pkg::OCC_BITS'(shadow_count);
    return r;
  endfunction

  function automatic head_result_t make_result(logic [smpq_pkg::VALUE_BITS-1:0] v,
                                               logic [smpq_pkg::PRIORITY_BITS-1:0] p,
                                               int occ, logic empty,
                                               smpq_pkg::fault_t f);
    head_result_t r;
    r.head_value    = v;
    r.head_priority = p;
    r.occupancy     = smpq_pkg::OCC_BITS'(occ);
    r.is_empty      = empty;
    r.fault         = f;
    return r;
  endfunction

  function automatic void add_row(smpq_pkg::kind_t k, logic [smpq_pkg::VALUE_BITS-1:0] v,
                                  logic [smpq_pkg::PRIORITY_BITS-1:0] p, bit typed,
                                  head_result_t want);
    stim_row_t row;
    row.kind  = k;
    row.value = v;
    row.prio  = p;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  // Offers one item and returns at the falling edge after it has been taken.
  task automatic offer_item(stim_row_t row);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    offered_items.push_back(row);
    in_bus.valid         <= 1'b1;
    in_bus.kind          <= row.kind;
    in_bus.item_value    <= row.value;
    in_bus.item_priority <= row.prio;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    @(negedge clk);
    while (pending_heads.size() != 0) @(negedge clk);
  endtask

  // Result side: random stalls, or a long hold-off when one is requested.
  initial begin
    out_bus.ready = 1'b0;
    hold_count    = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_bus.ready <= 1'b0;
        hold_count++;
        if (hold_count >= HOLD_CYCLES) begin
          hold_req   = 1'b0;
          hold_count = 0;
        end
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    head_result_t got;
    head_result_t want;
    stim_row_t    row;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        got = {out_bus.head_value, out_bus.head_priority, out_bus.occupancy,
               out_bus.is_empty, out_bus.fault};
        if (pending_heads.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("unexpected result: value %h prio %h occ %0d empty %b fault %0d",
                     got.head_value, got.head_priority, got.occupancy, got.is_empty,
                     got.fault);
        end else begin
          want = pending_heads.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display({"mismatch: expected value %h prio %h occ %0d empty %b fault %0d,",
                        " got value %h prio %h occ %0d empty %b fault %0d"},
                       want.head_value, want.head_priority, want.occupancy,
                       want.is_empty, want.fault, got.head_value, got.head_priority,
                       got.occupancy, got.is_empty, got.fault);
          end
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        row  = offered_items.pop_front();
        want = predict_queue_op(row);
        pending_heads.push_back(row.typed ? row.want : want);
      end
    end
  end

  initial begin
    stim_row_t row;
    int        tie_prios [14] = '{5, 5, 3, 65535, 0, 7, 3, 1, 65535, 2, 5, 0, 8, 4};
    int        n;
    int        mode;
    int        enq_pct;
    int        run_left;
    rst_n                = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.kind          = smpq_pkg::KIND_ENQ;
    in_bus.item_value    = '0;
    in_bus.item_priority = '0;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    hold_req             = 1'b0;
    fail_count           = 0;
    shadow_count         = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    add_row(smpq_pkg::KIND_DEQ, '1, '1, 1'b1,
            make_result('0, '0, 0, 1'b1, smpq_pkg::FAULT_EMPTY));
    add_row(smpq_pkg::KIND_ENQ, '1, '1, 1'b1,
            make_result('1, '1, 1, 1'b0, smpq_pkg::FAULT_OK));
    add_row(smpq_pkg::KIND_ENQ, '0, '0, 1'b1,
            make_result('0, '0, 2, 1'b0, smpq_pkg::FAULT_OK));
    // An equal priority queues behind the stored one, so the head stays put.
    add_row(smpq_pkg::KIND_ENQ, 32'd1, '0, 1'b1,
            make_result('0, '0, 3, 1'b0, smpq_pkg::FAULT_OK));
    add_row(smpq_pkg::KIND_DEQ, '0, '0, 1'b1,
            make_result(32'd1, '0, 2, 1'b0, smpq_pkg::FAULT_OK));
    for (n = 0; n < 14; n++)
      add_row(smpq_pkg::KIND_ENQ, 32'hA5A5_0000 + n,
              smpq_pkg::PRIORITY_BITS'(tie_prios[n]), 1'b0, '0);
    add_row(smpq_pkg::KIND_ENQ, 32'h5A5A_5A5A, '0, 1'b1,
            make_result(32'd1, '0, 16, 1'b0, smpq_pkg::FAULT_FULL));
    add_row(smpq_pkg::KIND_ENQ, 32'h0F0F_0F0F, '1, 1'b1,
            make_result(32'd1, '0, 16, 1'b0, smpq_pkg::FAULT_FULL));
    for (n = 0; n < 4; n++)
      add_row(smpq_pkg::KIND_DEQ, 32'hFFFF_0000, 16'h00FF, 1'b0, '0);

    foreach (directed_rows[i]) offer_item(directed_rows[i]);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          // The block backs up while the result side holds off.
          hold_req       = 1'b1;
        end
        1: begin
          send_idle_pct  = 62;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 62;
        end
        default: begin
          send_idle_pct  = 36;
          recv_stall_pct = 36;
        end
      endcase
      n = 0;
      while (n < RANDOM_PER_PHASE) begin
        // Runs biased towards filling, draining or neither, so full and empty recur.
        mode     = $urandom_range(0, 2);
        enq_pct  = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
        run_left = $urandom_range(6, 40);
        while (run_left > 0 && n < RANDOM_PER_PHASE) begin
          row.kind  = ($urandom_range(0, 99) < enq_pct) ? smpq_pkg::KIND_ENQ
                                                        : smpq_pkg::KIND_DEQ;
          row.value = $urandom();
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: row.prio = smpq_pkg::PRIORITY_BITS'($urandom_range(0, 7));
            5, 6, 7:       row.prio = smpq_pkg::PRIORITY_BITS'($urandom_range(0, 65535));
            8:             row.prio = '0;
            default:       row.prio = '1;
          endcase
          row.typed = 1'b0;
          row.want  = '0;
          offer_item(row);
          n++;
          run_left--;
        end
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (pending_heads.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

endmodule
